// File: design/csi_erase_range_detector_macros.svh
// ----------------------------------------------------------------------------
// csi_erase_range_detector_macros
// assertion macros shared by the erase range detector modules
// ----------------------------------------------------------------------------
`ifndef CSI_ERASE_RANGE_DETECTOR_MACROS_SVH
`define CSI_ERASE_RANGE_DETECTOR_MACROS_SVH

// condition holds at every clock edge out of reset
`define CERD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CERD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/cerd_pkg.sv
// ----------------------------------------------------------------------------
// cerd_pkg
// shared types and constants of the erase range detector
// ----------------------------------------------------------------------------
`default_nettype none

package cerd_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 1024;

  localparam int ROW_W  = 8;
  localparam int COL_W  = 10;
  localparam int ROWS_W = 9;
  localparam int COLS_W = 11;
  localparam int LEN_W  = 8;
  localparam int PAR_W  = 16;

  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(24);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(128);

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_LEN  = 2'd2;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_J     = 8'h4a;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7e;

  localparam logic [PAR_W-1:0] PAR_MAX = '1;

  localparam logic [2:0] OP_K0 = 3'd0;
  localparam logic [2:0] OP_K1 = 3'd1;
  localparam logic [2:0] OP_K2 = 3'd2;
  localparam logic [2:0] OP_J0 = 3'd3;
  localparam logic [2:0] OP_J1 = 3'd4;
  localparam logic [2:0] OP_J2 = 3'd5;

  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_ROWS = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]       op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/cerd_front.sv
// ----------------------------------------------------------------------------
// cerd_front
// control sequence parser, turns completed erase sequences into commands
// ----------------------------------------------------------------------------
`default_nettype none

module cerd_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [31:0]                    s_tdata,  // data_byte, cursor_row, cursor_col
  input  wire logic [cerd_pkg::LEN_W-1:0]     max_len,
  input  wire logic                           q_full,
  output logic                                push,
  output cerd_pkg::cmd_t                      push_cmd
);

  localparam logic [1:0] PH_GROUND = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_SEQ    = 2'd2;

  logic [1:0]                  phase, phase_next;
  logic [cerd_pkg::LEN_W-1:0]  seq_len, seq_len_next;
  logic [cerd_pkg::PAR_W-1:0]  par, par_next;
  logic                        ended, ended_next;
  logic                        invalid, invalid_next;

  logic                        accept;
  logic [7:0]                  byte_in;
  logic                        is_esc, is_final, is_digit, is_end, at_limit;
  logic [19:0]                 prod;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign byte_in  = s_tdata[7:0];
  assign is_esc   = byte_in == cerd_pkg::CH_ESC;
  assign is_final = byte_in >= cerd_pkg::FINAL_LO && byte_in <= cerd_pkg::FINAL_HI;
  assign is_digit = byte_in >= cerd_pkg::CH_ZERO && byte_in <= cerd_pkg::CH_NINE;
  assign is_end   = byte_in == cerd_pkg::CH_SEMI || byte_in == cerd_pkg::CH_COLON ||
                    byte_in == cerd_pkg::CH_NUL;
  assign at_limit = seq_len >= max_len;
  assign prod     = 20'(par) * 20'd10 + 20'(byte_in - cerd_pkg::CH_ZERO);

  always_comb begin
    phase_next   = phase;
    seq_len_next = seq_len;
    par_next     = par;
    ended_next   = ended;
    invalid_next = invalid;
    push         = 1'b0;
    push_cmd.op  = cerd_pkg::OP_K0;
    push_cmd.row = s_tdata[15:8];
    push_cmd.col = s_tdata[25:16];
    if (accept) begin
      unique case (phase)
        PH_GROUND, PH_ESC: begin
          par_next     = '0;
          ended_next   = 1'b0;
          invalid_next = 1'b0;
          if (is_esc && max_len != '0) begin
            phase_next   = PH_ESC;
            seq_len_next = cerd_pkg::LEN_W'(1);
          end else if (phase == PH_ESC && byte_in == cerd_pkg::CH_LBR && !at_limit) begin
            phase_next   = PH_SEQ;
            seq_len_next = seq_len + 1'b1;
          end else begin
            phase_next   = PH_GROUND;
            seq_len_next = '0;
          end
        end
        PH_SEQ: begin
          if (is_final) begin
            phase_next   = PH_GROUND;
            seq_len_next = '0;
            par_next     = '0;
            ended_next   = 1'b0;
            invalid_next = 1'b0;
            if (!invalid) begin
              if (byte_in == cerd_pkg::CH_K) begin
                if (par == cerd_pkg::PAR_W'(0)) begin
                  push = 1'b1; push_cmd.op = cerd_pkg::OP_K0;
                end else if (par == cerd_pkg::PAR_W'(1)) begin
                  push = 1'b1; push_cmd.op = cerd_pkg::OP_K1;
                end else if (par == cerd_pkg::PAR_W'(2)) begin
                  push = 1'b1; push_cmd.op = cerd_pkg::OP_K2;
                end
              end else if (byte_in == cerd_pkg::CH_J) begin
                if (par == cerd_pkg::PAR_W'(0)) begin
                  push = 1'b1; push_cmd.op = cerd_pkg::OP_J0;
                end else if (par == cerd_pkg::PAR_W'(1)) begin
                  push = 1'b1; push_cmd.op = cerd_pkg::OP_J1;
                end else if (par == cerd_pkg::PAR_W'(2) || par == cerd_pkg::PAR_W'(3)) begin
                  push = 1'b1; push_cmd.op = cerd_pkg::OP_J2;
                end
              end
            end
          end else begin
            if (!ended && !invalid) begin
              if (is_digit) begin
                par_next = (prod > 20'(cerd_pkg::PAR_MAX)) ? cerd_pkg::PAR_MAX
                                                            : prod[cerd_pkg::PAR_W-1:0];
              end else if (is_end) begin
                ended_next = 1'b1;
              end else begin
                invalid_next = 1'b1;
              end
            end
            if (at_limit) begin
              par_next     = '0;
              ended_next   = 1'b0;
              invalid_next = 1'b0;
              if (is_esc && max_len != '0) begin
                phase_next   = PH_ESC;
                seq_len_next = cerd_pkg::LEN_W'(1);
              end else begin
                phase_next   = PH_GROUND;
                seq_len_next = '0;
              end
            end else begin
              seq_len_next = seq_len + 1'b1;
            end
          end
        end
        default: begin
          phase_next   = PH_GROUND;
          seq_len_next = '0;
          par_next     = '0;
          ended_next   = 1'b0;
          invalid_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_GROUND;
      seq_len <= '0;
      par     <= '0;
      ended   <= 1'b0;
      invalid <= 1'b0;
    end else begin
      phase   <= phase_next;
      seq_len <= seq_len_next;
      par     <= par_next;
      ended   <= ended_next;
      invalid <= invalid_next;
    end
  end

endmodule

`default_nettype wire

// File: design/cerd_queue.sv
// ----------------------------------------------------------------------------
// cerd_queue
// short command queue between parser and range generator
// ----------------------------------------------------------------------------
`default_nettype none

`include "csi_erase_range_detector_macros.svh"

module cerd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cerd_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output cerd_pkg::cmd_t      head
);

  cerd_pkg::cmd_t                entries [cerd_pkg::QDEPTH];
  logic [cerd_pkg::QAW-1:0]      wr_ptr, rd_ptr;
  logic [cerd_pkg::QCW-1:0]      count;
  logic                          do_push, do_pop;

  assign full    = count == cerd_pkg::QCW'(cerd_pkg::QDEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == cerd_pkg::QAW'(cerd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == cerd_pkg::QAW'(cerd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CERD_ASSERT_IMPLIES(a_no_push_full, push, !full, "command pushed into full queue")
  `CERD_ASSERT_HOLDS(a_count_range, count <= cerd_pkg::QCW'(cerd_pkg::QDEPTH), "queue count overflow")

endmodule

`default_nettype wire

// File: design/cerd_back.sv
// ----------------------------------------------------------------------------
// cerd_back
// expands queued erase commands into one or two fill ranges
// ----------------------------------------------------------------------------
`default_nettype none

`include "csi_erase_range_detector_macros.svh"

module cerd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [cerd_pkg::ROWS_W-1:0]   screen_rows,
  input  wire logic [cerd_pkg::COLS_W-1:0]   screen_cols,
  input  wire logic                          q_empty,
  input  wire cerd_pkg::cmd_t                head,
  output logic                               pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [39:0]                        m_tdata,  // row_first, row_last, col_first, col_last
  output logic                               m_tlast,  // last_of_run
  output logic [0:0]                         m_tuser   // fill_kind
);

  logic [cerd_pkg::ROWS_W-1:0] rows_c;
  logic [cerd_pkg::COLS_W-1:0] cols_c;
  logic [cerd_pkg::ROW_W-1:0]  row_max, r;
  logic [cerd_pkg::COL_W-1:0]  col_max, c;
  logic                        step;
  logic                        load, has_two, is_last;

  logic                        kind;
  logic [cerd_pkg::ROW_W-1:0]  row_first, row_last;
  logic [cerd_pkg::COL_W-1:0]  col_first, col_last;

  assign rows_c = (screen_rows == '0) ? cerd_pkg::ROWS_W'(1) :
                  (screen_rows > cerd_pkg::ROWS_W'(cerd_pkg::MAX_ROWS)) ?
                  cerd_pkg::ROWS_W'(cerd_pkg::MAX_ROWS) : screen_rows;
  assign cols_c = (screen_cols == '0) ? cerd_pkg::COLS_W'(1) :
                  (screen_cols > cerd_pkg::COLS_W'(cerd_pkg::MAX_COLS)) ?
                  cerd_pkg::COLS_W'(cerd_pkg::MAX_COLS) : screen_cols;
  assign row_max = cerd_pkg::ROW_W'(rows_c - 1'b1);
  assign col_max = cerd_pkg::COL_W'(cols_c - 1'b1);
  assign r = (head.row > row_max) ? row_max : head.row;
  assign c = (head.col > col_max) ? col_max : head.col;

  always_comb begin
    has_two   = 1'b0;
    kind      = cerd_pkg::KIND_SPAN;
    row_first = r;
    row_last  = r;
    col_first = '0;
    col_last  = col_max;
    unique case (head.op)
      cerd_pkg::OP_K0: begin
        col_first = c;
      end
      cerd_pkg::OP_K1: begin
        col_last = c;
      end
      cerd_pkg::OP_K2: begin
      end
      cerd_pkg::OP_J0: begin
        has_two = r != row_max;
        if (step) begin
          kind      = cerd_pkg::KIND_ROWS;
          row_first = r + 1'b1;
          row_last  = row_max;
        end else begin
          col_first = c;
        end
      end
      cerd_pkg::OP_J1: begin
        has_two = r != '0;
        if (has_two && !step) begin
          kind      = cerd_pkg::KIND_ROWS;
          row_first = '0;
          row_last  = r - 1'b1;
        end else begin
          col_last = c;
        end
      end
      cerd_pkg::OP_J2: begin
        kind      = cerd_pkg::KIND_ROWS;
        row_first = '0;
        row_last  = row_max;
      end
      default: begin
      end
    endcase
  end

  assign is_last = !has_two || step;
  assign load    = !q_empty && (!m_tvalid || m_tready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      step     <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      step     <= !is_last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= {4'b0, col_last, col_first, row_last, row_first};
      m_tlast    <= is_last;
      m_tuser[0] <= kind;
    end
  end

  `CERD_ASSERT_IMPLIES(a_span_one_row, m_tvalid && m_tuser[0] == cerd_pkg::KIND_SPAN,
                       m_tdata[7:0] == m_tdata[15:8], "span covers more than one row")
  `CERD_ASSERT_IMPLIES(a_order, m_tvalid,
                       m_tdata[25:16] <= m_tdata[35:26] && m_tdata[7:0] <= m_tdata[15:8],
                       "range bounds out of order")
  `CERD_ASSERT_IMPLIES(a_step_head, step, !q_empty, "second range pending without command")

endmodule

`default_nettype wire

// File: design/csi_erase_range_detector.sv
// path: a final byte's command is written into the command queue, then its first range into the output register
// throughput: one byte per cycle while the queue is not full; a command giving two ranges holds the output for both
// the two-entry command queue stalls the input only when it is full
// reset: synchronous, parser to ground, queue and output emptied, registers to 24/80/128
// ----------------------------------------------------------------------------
// csi_erase_range_detector
// finds erase line and erase display sequences and emits fill ranges
// ----------------------------------------------------------------------------
`default_nettype none

module csi_erase_range_detector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // data_byte, cursor_row, cursor_col
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // row_first, row_last, col_first, col_last
  output logic             m_tlast,  // last_of_run
  output logic [0:0]       m_tuser,  // fill_kind
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [10:0] cfg_data
);

  logic [cerd_pkg::ROWS_W-1:0] screen_rows;
  logic [cerd_pkg::COLS_W-1:0] screen_cols;
  logic [cerd_pkg::LEN_W-1:0]  max_len;

  logic           q_full, q_empty, push, pop;
  cerd_pkg::cmd_t push_cmd, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= cerd_pkg::ROWS_RESET;
      screen_cols <= cerd_pkg::COLS_RESET;
      max_len     <= cerd_pkg::LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cerd_pkg::REG_ROWS: screen_rows <= cfg_data[cerd_pkg::ROWS_W-1:0];
        cerd_pkg::REG_COLS: screen_cols <= cfg_data[cerd_pkg::COLS_W-1:0];
        cerd_pkg::REG_LEN:  max_len     <= cfg_data[cerd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cerd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .max_len  (max_len),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cerd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  cerd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .screen_rows (screen_rows),
    .screen_cols (screen_cols),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

// File: bench/tb_csi_erase_range_detector.sv
// ----------------------------------------------------------------------------
// tb_csi_erase_range_detector
// drives terminal bytes with cursor positions through the erase range
// detector and compares every fill range against a cycle-free predictor
// ----------------------------------------------------------------------------
module tb_csi_erase_range_detector;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SCAN_GROUND, SCAN_ESC, SCAN_PARAM} scan_t;
  typedef enum int {PACE_FULL, PACE_SOME, PACE_SLOW} pace_t;

  typedef struct packed {
    logic [7:0]                 data_byte;
    logic [cerd_pkg::ROW_W-1:0] cursor_row;
    logic [cerd_pkg::COL_W-1:0] cursor_col;
  } stream_item_t;

  typedef struct packed {
    logic                       kind;
    logic [cerd_pkg::ROW_W-1:0] row_first;
    logic [cerd_pkg::ROW_W-1:0] row_last;
    logic [cerd_pkg::COL_W-1:0] col_first;
    logic [cerd_pkg::COL_W-1:0] col_last;
    logic                       last;
  } fill_t;

  localparam logic [cerd_pkg::PAR_W-1:0] MODE_TO_END    = 16'd0;
  localparam logic [cerd_pkg::PAR_W-1:0] MODE_TO_CURSOR = 16'd1;
  localparam logic [cerd_pkg::PAR_W-1:0] MODE_ALL       = 16'd2;
  localparam logic [cerd_pkg::PAR_W-1:0] MODE_SAVED     = 16'd3;
  localparam int HOLD_CYCLES = 200;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        cfg_we   = 1'b0;
  logic [1:0]  cfg_addr = cerd_pkg::REG_ROWS;
  logic [10:0] cfg_data = '0;

  csi_erase_range_detector u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state and register copies
  logic [cerd_pkg::ROWS_W-1:0] scr_rows = cerd_pkg::ROWS_RESET;
  logic [cerd_pkg::COLS_W-1:0] scr_cols = cerd_pkg::COLS_RESET;
  logic [cerd_pkg::LEN_W-1:0]  pend_max = cerd_pkg::LEN_RESET;
  scan_t                       scan     = SCAN_GROUND;
  logic [cerd_pkg::LEN_W-1:0]  seq_len  = '0;
  logic [cerd_pkg::PAR_W-1:0]  par      = '0;
  bit                          par_done = 1'b0;
  bit                          par_bad  = 1'b0;

  stream_item_t stream_q[$];
  fill_t        fill_q[$];
  stream_item_t drv_item;

  pace_t send_pace = PACE_FULL;
  pace_t recv_pace = PACE_FULL;
  int    send_wait = 0;
  int    recv_wait = 0;
  int    recv_draw;
  int    hold_left = 0;
  int    hold_ticket = 0;
  int    hold_seen = 0;

  int bytes_in    = 0;
  int fills_seen  = 0;
  int mismatches  = 0;
  int settings    = 0;
  int queued      = 0;

  function automatic int pace_draw(input pace_t p);
    case (p)
      PACE_FULL: return 0;
      PACE_SOME: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
      default:   return $urandom_range(0, 18);
    endcase
  endfunction

  // ---------------- predictor ----------------
  function automatic void clear_scan();
    scan     = SCAN_GROUND;
    seq_len  = '0;
    par      = '0;
    par_done = 1'b0;
    par_bad  = 1'b0;
  endfunction

  function automatic void extend_or_drop(input logic [7:0] b);
    if (seq_len >= pend_max) begin
      clear_scan();
      if (b == cerd_pkg::CH_ESC && pend_max >= 1) begin
        scan    = SCAN_ESC;
        seq_len = 8'd1;
      end
    end else begin
      seq_len = seq_len + 8'd1;
    end
  endfunction

  function automatic fill_t make_fill(input logic kind, input int r0, input int r1,
                                      input int c0, input int c1);
    fill_t f;
    f.kind      = kind;
    f.row_first = cerd_pkg::ROW_W'(r0);
    f.row_last  = cerd_pkg::ROW_W'(r1);
    f.col_first = cerd_pkg::COL_W'(c0);
    f.col_last  = cerd_pkg::COL_W'(c1);
    f.last      = 1'b0;
    return f;
  endfunction

  function automatic void queue_fills(input logic [7:0] cmd,
                                      input logic [cerd_pkg::PAR_W-1:0] mode,
                                      input logic [cerd_pkg::ROW_W-1:0] crow,
                                      input logic [cerd_pkg::COL_W-1:0] ccol);
    int rows, cols, r, c;
    fill_t fl[$];
    rows = (scr_rows < 1) ? 1 : (scr_rows > cerd_pkg::MAX_ROWS) ? cerd_pkg::MAX_ROWS
                                                                 : int'(scr_rows);
    cols = (scr_cols < 1) ? 1 : (scr_cols > cerd_pkg::MAX_COLS) ? cerd_pkg::MAX_COLS
                                                                 : int'(scr_cols);
    r = (crow > rows - 1) ? rows - 1 : int'(crow);
    c = (ccol > cols - 1) ? cols - 1 : int'(ccol);
    if (cmd == cerd_pkg::CH_K) begin
      if (mode == MODE_TO_END)
        fl = {fl, make_fill(cerd_pkg::KIND_SPAN, r, r, c, cols - 1)};
      else if (mode == MODE_TO_CURSOR)
        fl = {fl, make_fill(cerd_pkg::KIND_SPAN, r, r, 0, c)};
      else if (mode == MODE_ALL)
        fl = {fl, make_fill(cerd_pkg::KIND_SPAN, r, r, 0, cols - 1)};
    end else if (cmd == cerd_pkg::CH_J) begin
      if (mode == MODE_TO_END) begin
        fl = {fl, make_fill(cerd_pkg::KIND_SPAN, r, r, c, cols - 1)};
        if (r + 1 <= rows - 1)
          fl = {fl, make_fill(cerd_pkg::KIND_ROWS, r + 1, rows - 1, 0, cols - 1)};
      end else if (mode == MODE_TO_CURSOR) begin
        if (r >= 1) fl = {fl, make_fill(cerd_pkg::KIND_ROWS, 0, r - 1, 0, cols - 1)};
        fl = {fl, make_fill(cerd_pkg::KIND_SPAN, r, r, 0, c)};
      end else if (mode == MODE_ALL || mode == MODE_SAVED) begin
        fl = {fl, make_fill(cerd_pkg::KIND_ROWS, 0, rows - 1, 0, cols - 1)};
      end
    end
    if (fl.size() != 0) fl[fl.size() - 1].last = 1'b1;
    fill_q = {fill_q, fl};
  endfunction

  function automatic void predict_byte(input stream_item_t it);
    logic [7:0]                 b;
    bit                         ok;
    logic [cerd_pkg::PAR_W-1:0] mode;
    int                         v;
    b = it.data_byte;
    case (scan)
      SCAN_GROUND: begin
        if (b == cerd_pkg::CH_ESC) begin
          clear_scan();
          scan = SCAN_ESC;
          extend_or_drop(b);
        end
      end
      SCAN_ESC: begin
        if (b == cerd_pkg::CH_ESC) begin
          clear_scan();
          scan = SCAN_ESC;
          extend_or_drop(b);
        end else if (b == cerd_pkg::CH_LBR) begin
          par      = '0;
          par_done = 1'b0;
          par_bad  = 1'b0;
          scan     = SCAN_PARAM;
          extend_or_drop(b);
        end else begin
          clear_scan();
        end
      end
      default: begin
        if (b >= cerd_pkg::FINAL_LO && b <= cerd_pkg::FINAL_HI) begin
          ok   = !par_bad;
          mode = par;
          clear_scan();
          if (ok) queue_fills(b, mode, it.cursor_row, it.cursor_col);
        end else begin
          if (!par_done && !par_bad) begin
            if (b >= cerd_pkg::CH_ZERO && b <= cerd_pkg::CH_NINE) begin
              v   = int'(par) * 10 + int'(b - cerd_pkg::CH_ZERO);
              par = (v > int'(cerd_pkg::PAR_MAX)) ? cerd_pkg::PAR_MAX : cerd_pkg::PAR_W'(v);
            end else if (b == cerd_pkg::CH_SEMI || b == cerd_pkg::CH_COLON ||
                         b == cerd_pkg::CH_NUL) begin
              par_done = 1'b1;
            end else begin
              par_bad = 1'b1;
            end
          end
          extend_or_drop(b);
        end
      end
    endcase
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      send_wait <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_wait != 0) begin
        s_tvalid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (stream_q.size() != 0) begin
        drv_item = stream_q[0];
        stream_q.delete(0);
        s_tdata   <= {6'b0, drv_item.cursor_col, drv_item.cursor_row, drv_item.data_byte};
        s_tvalid  <= 1'b1;
        send_wait <= pace_draw(send_pace);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= (hold_left == 1);
    end else if (m_tvalid && m_tready) begin
      recv_draw = pace_draw(recv_pace);
      recv_wait <= recv_draw;
      m_tready  <= (recv_draw == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      m_tready  <= (recv_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------- monitor ----------------
  function automatic void check_fill();
    fill_t want, got;
    string bad;
    got.kind      = m_tuser[0];
    got.row_first = m_tdata[7:0];
    got.row_last  = m_tdata[15:8];
    got.col_first = m_tdata[25:16];
    got.col_last  = m_tdata[35:26];
    got.last      = m_tlast;
    fills_seen++;
    if (fill_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected range kind=%0d rows %0d..%0d cols %0d..%0d last=%0d",
                 $realtime, got.kind, got.row_first, got.row_last, got.col_first,
                 got.col_last, got.last);
      return;
    end
    want = fill_q[0];
    fill_q.delete(0);
    bad = "";
    if (got.kind !== want.kind) bad = {bad, " kind"};
    if (got.row_first !== want.row_first) bad = {bad, " row_first"};
    if (got.row_last !== want.row_last) bad = {bad, " row_last"};
    if (got.col_first !== want.col_first) bad = {bad, " col_first"};
    if (got.col_last !== want.col_last) bad = {bad, " col_last"};
    if (got.last !== want.last) bad = {bad, " last"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: range mismatch in%s", $realtime, bad);
        $display("  exp kind=%0d rows %0d..%0d cols %0d..%0d last=%0d", want.kind,
                 want.row_first, want.row_last, want.col_first, want.col_last, want.last);
        $display("  got kind=%0d rows %0d..%0d cols %0d..%0d last=%0d", got.kind,
                 got.row_first, got.row_last, got.col_first, got.col_last, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_byte(stream_item_t'({s_tdata[7:0], s_tdata[15:8], s_tdata[25:16]}));
      bytes_in++;
    end
    if (!rst && m_tvalid && m_tready) check_fill();
  end

  // ---------------- stimulus ----------------
  function automatic void push_at(input logic [7:0] b, input int row, input int col);
    stream_item_t it;
    it.data_byte  = b;
    it.cursor_row = cerd_pkg::ROW_W'(row);
    it.cursor_col = cerd_pkg::COL_W'(col);
    stream_q = {stream_q, it};
    queued++;
  endfunction

  function automatic void push_item(input logic [7:0] b);
    int lr, lc, sel;
    lr  = (scr_rows == 0) ? 0 : (scr_rows > cerd_pkg::MAX_ROWS) ? cerd_pkg::MAX_ROWS - 1
                                                                 : int'(scr_rows) - 1;
    lc  = (scr_cols == 0) ? 0 : (scr_cols > cerd_pkg::MAX_COLS) ? cerd_pkg::MAX_COLS - 1
                                                                 : int'(scr_cols) - 1;
    sel = $urandom_range(0, 5);
    if (sel < 2) push_at(b, $urandom_range(0, 255), $urandom_range(0, 1023));
    else if (sel < 5) push_at(b, $urandom_range(0, lr), $urandom_range(0, lc));
    else push_at(b, ($urandom_range(0, 1) != 0) ? lr : 0, ($urandom_range(0, 1) != 0) ? lc : 0);
  endfunction

  function automatic void push_text(input string s);
    foreach (s[i]) push_item(s[i]);
  endfunction

  function automatic logic [7:0] non_final_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b >= cerd_pkg::FINAL_LO && b <= cerd_pkg::FINAL_HI);
    return b;
  endfunction

  function automatic logic [7:0] breaking_byte();
    logic [7:0] b;
    do b = non_final_byte();
    while ((b >= cerd_pkg::CH_ZERO && b <= cerd_pkg::CH_NINE) || b == cerd_pkg::CH_SEMI ||
           b == cerd_pkg::CH_COLON || b == cerd_pkg::CH_NUL);
    return b;
  endfunction

  function automatic logic [7:0] end_mark();
    case ($urandom_range(0, 2))
      0:       return cerd_pkg::CH_SEMI;
      1:       return cerd_pkg::CH_COLON;
      default: return cerd_pkg::CH_NUL;
    endcase
  endfunction

  function automatic void param_bytes();
    int n;
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4: push_text($sformatf("%0d", ($urandom_range(0, 4) == 0) ?
                                   $urandom_range(0, 9) : $urandom_range(0, 3)));
      5: begin
        repeat ($urandom_range(1, 3)) push_item(cerd_pkg::CH_ZERO);
        push_text($sformatf("%0d", $urandom_range(0, 3)));
      end
      6: begin
        if ($urandom_range(0, 3) != 0) push_text($sformatf("%0d", $urandom_range(0, 3)));
        push_item(end_mark());
        repeat ($urandom_range(0, 3)) push_item(non_final_byte());
      end
      7: begin
        case ($urandom_range(0, 3))
          0:       push_text("65535");
          1:       push_text("65536");
          default: push_text($sformatf("%0d", $urandom_range(10000, 9999999)));
        endcase
      end
      8: begin
        if ($urandom_range(0, 1) != 0) push_text($sformatf("%0d", $urandom_range(0, 3)));
        push_item(($urandom_range(0, 3) == 0) ? cerd_pkg::CH_ESC : breaking_byte());
      end
      default: begin
        n = (pend_max < 10) ? int'(pend_max) + 2 : 12;
        repeat ($urandom_range(1, n)) push_item(non_final_byte());
      end
    endcase
  endfunction

  function automatic logic [7:0] final_byte();
    if ($urandom_range(0, 9) < 8)
      return ($urandom_range(0, 1) != 0) ? cerd_pkg::CH_K : cerd_pkg::CH_J;
    return 8'($urandom_range(cerd_pkg::FINAL_LO, cerd_pkg::FINAL_HI));
  endfunction

  function automatic void random_sequence();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) push_item(8'($urandom_range(0, 255)));
    end else if (pick < 14) begin
      push_item(cerd_pkg::CH_ESC);
      do b = 8'($urandom_range(0, 255));
      while (b == cerd_pkg::CH_LBR || b == cerd_pkg::CH_ESC);
      push_item(b);
    end else begin
      if (pick < 19) push_item(cerd_pkg::CH_ESC);
      push_item(cerd_pkg::CH_ESC);
      push_item(cerd_pkg::CH_LBR);
      param_bytes();
      push_item(final_byte());
    end
  endfunction

  function automatic void fill_random(input int n);
    int stop;
    stop = queued + n;
    while (queued < stop) random_sequence();
  endfunction

  function automatic void long_sequence(input int body);
    push_item(cerd_pkg::CH_ESC);
    push_item(cerd_pkg::CH_LBR);
    push_text("2;");
    repeat (body - 2) push_item(8'($urandom_range(cerd_pkg::CH_ZERO, cerd_pkg::CH_NINE)));
    push_item(cerd_pkg::CH_J);
  endfunction

  task automatic wait_quiet();
    do @(negedge clk); while (stream_q.size() != 0 || s_tvalid || fill_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cerd_pkg::REG_ROWS: scr_rows = val[cerd_pkg::ROWS_W-1:0];
      cerd_pkg::REG_COLS: scr_cols = val[cerd_pkg::COLS_W-1:0];
      default:            pend_max = val[cerd_pkg::LEN_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic set_screen(input int rows, input int cols, input int maxlen);
    wait_quiet();
    write_reg(cerd_pkg::REG_ROWS, 11'(rows));
    write_reg(cerd_pkg::REG_COLS, 11'(cols));
    write_reg(cerd_pkg::REG_LEN, 11'(maxlen));
    settings++;
  endtask

  function automatic int rand_dim(input int hi, input int width);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(hi + 1, (1 << width) - 1);
    if (sel == 2) return hi;
    return $urandom_range(1, hi);
  endfunction

  initial begin
    int maxlen;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: each erase flavor, clamping, restart on doubled escape
    push_at(cerd_pkg::CH_ESC, 0, 0); push_at(cerd_pkg::CH_LBR, 0, 0);
    push_at(cerd_pkg::CH_K, 5, 10);
    push_at(cerd_pkg::CH_ESC, 0, 0); push_at(cerd_pkg::CH_LBR, 0, 0); push_at("1", 0, 0);
    push_at(cerd_pkg::CH_K, 255, 1023);
    push_at(cerd_pkg::CH_ESC, 0, 0); push_at(cerd_pkg::CH_LBR, 0, 0); push_at("2", 0, 0);
    push_at(cerd_pkg::CH_K, 0, 0);
    push_at(cerd_pkg::CH_ESC, 0, 0); push_at(cerd_pkg::CH_LBR, 0, 0);
    push_at(cerd_pkg::CH_J, 0, 79);
    push_at(cerd_pkg::CH_ESC, 0, 0); push_at(cerd_pkg::CH_LBR, 0, 0); push_at("1", 0, 0);
    push_at(cerd_pkg::CH_J, 0, 0);
    push_at(cerd_pkg::CH_ESC, 0, 0); push_at(cerd_pkg::CH_LBR, 0, 0); push_at("3", 0, 0);
    push_at(cerd_pkg::CH_J, 7, 3);
    push_at(cerd_pkg::CH_ESC, 0, 0); push_at(cerd_pkg::CH_ESC, 0, 0);
    push_at(cerd_pkg::CH_LBR, 0, 0); push_at("2", 0, 0);
    push_at(cerd_pkg::CH_J, 23, 5);
    wait_quiet();

    // receiver holds off while the sender keeps offering commands
    hold_ticket = hold_ticket + 1;
    repeat (12) begin
      push_item(cerd_pkg::CH_ESC);
      push_text("[2J");
      push_item(cerd_pkg::CH_ESC);
      push_text("[J");
      push_item(cerd_pkg::CH_ESC);
      push_text("[1J");
    end
    wait_quiet();

    send_pace = PACE_SOME; recv_pace = PACE_SOME;
    set_screen(1, 1, 255);
    fill_random(200);

    send_pace = PACE_SLOW; recv_pace = PACE_FULL;
    set_screen(256, 1024, 2);
    fill_random(200);

    send_pace = PACE_FULL; recv_pace = PACE_SLOW;
    set_screen(0, 0, 0);
    fill_random(60);
    set_screen(511, 2047, 1);
    fill_random(60);

    send_pace = PACE_SOME; recv_pace = PACE_SLOW;
    set_screen(256, 1024, 255);
    long_sequence(253);
    long_sequence(254);
    fill_random(100);

    repeat (4) begin
      send_pace = pace_t'($urandom_range(0, 2));
      recv_pace = pace_t'($urandom_range(0, 2));
      maxlen = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 20) : $urandom_range(100, 255);
      set_screen(rand_dim(cerd_pkg::MAX_ROWS, cerd_pkg::ROWS_W),
                 rand_dim(cerd_pkg::MAX_COLS, cerd_pkg::COLS_W), maxlen);
      fill_random(160);
    end

    send_pace = PACE_FULL; recv_pace = PACE_FULL;
    set_screen(24, 80, 128);
    fill_random(150);

    wait_quiet();
    repeat (10) @(negedge clk);
    mismatches = mismatches + fill_q.size();
    $display("run covered %0d bytes in %0d register settings, %0d fill ranges checked",
             bytes_in, settings + 1, fills_seen);
    $display("mismatching or missing ranges: %0d", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d ranges still expected", fill_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
